/* src/skht_pkg.sv */
package skht_pkg;

  // Fixed field widths of the item channels.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 9;
  localparam int unsigned OFFS_W     = 32;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned LIMIT_W    = 10;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = 3;

  // Stored name count saturates here.
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'd1023;
  // Reset value of the entry limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd491;
  // Register index of the entry limit.
  localparam logic               REG_LIMIT   = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [7:0]        key_char;
    logic              key_last;
    logic [OFFS_W-1:0] data_offset;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [OFFS_W-1:0]     found_offset;
    logic                  over_limit;
  } out_item_t;

endpackage

/* src/string_key_linear_probe_hash_table_core.sv */
// Name hash table with linear probing, names streamed one byte per beat.
// A byte that does not end a name is taken while idle. A final byte probes
// slot by slot, each with a memory read, then a compare, and then loads the
// result register; a name longer than the limit skips the probe. A clear beat
// sweeps the used bits one slot a cycle, then reports. After reset the same
// sweep runs.
module string_key_linear_probe_hash_table_core #(
  parameter int unsigned NUM_SLOTS      = 512,
  parameter int unsigned MAX_NAME_BYTES = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  skht_pkg::in_item_t           in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output skht_pkg::out_item_t          out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [skht_pkg::ADDR_W-1:0]  paddr,
  input  logic [skht_pkg::DATA_W-1:0]  pwdata,
  output logic [skht_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import skht_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned LEN_W  = $clog2(MAX_NAME_BYTES + 1);
  localparam int unsigned IDX_W  = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

  localparam logic [SLOT_W:0]    SIZE_EXT  = (SLOT_W + 1)'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_NAME_BYTES);

  typedef struct packed {
    logic                               used;
    logic [LEN_W-1:0]                   len;
    logic [MAX_NAME_BYTES-1:0][7:0]     name;
    logic [OFFS_W-1:0]                  offs;
  } entry_t;

  // Each byte value reduced modulo the table size, built at elaboration.
  function automatic logic [255:0][SLOT_W-1:0] build_mod_tab();
    logic [255:0][SLOT_W-1:0] tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = SLOT_W'(i % NUM_SLOTS);
    end
    return tab;
  endfunction

  localparam logic [255:0][SLOT_W-1:0] MOD_TAB = build_mod_tab();

  state_e state_q, state_d;

  logic [SLOT_W-1:0]              sweep_q, sweep_d;
  logic                           clr_res_q, clr_res_d;
  logic [SLOT_W-1:0]              loc_q, loc_d;
  logic [SLOT_W-1:0]              probe_q, probe_d;
  logic [MAX_NAME_BYTES-1:0][7:0] name_q, name_d;
  logic [LEN_W-1:0]               len_q, len_d;
  logic [SLOT_W-1:0]              sum_q, sum_d;
  logic                           too_long_q, too_long_d;
  logic                           is_insert_q, is_insert_d;
  logic [OFFS_W-1:0]              offs_q, offs_d;
  logic [COUNT_W-1:0]             count_q, count_d;
  logic [LIMIT_W-1:0]             limit_q;
  status_e                        res_status_q, res_status_d;
  logic [SLOT_OUT_W-1:0]          res_slot_q, res_slot_d;
  logic [OFFS_W-1:0]              res_offs_q, res_offs_d;
  out_item_t                      out_q, out_d;
  logic                           out_valid_q, out_valid_d;

  entry_t                         mem [NUM_SLOTS];
  entry_t                         rd_q;
  logic                           we;
  logic [SLOT_W-1:0]              waddr;
  entry_t                         wdata;

  logic                           in_acc;
  logic                           out_load;
  logic                           byte_fits;
  logic                           name_long;
  logic [SLOT_W:0]                sum_ext;
  logic [SLOT_W-1:0]              sum_mod;
  logic [MAX_NAME_BYTES-1:0]      lane_ok;
  logic                           slot_hit;
  logic                           probe_end;

  // Configuration port: one register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Running hash: the byte sum is kept already reduced modulo the table size.
  assign byte_fits = (len_q < LEN_MAX);
  assign name_long = too_long_q || !byte_fits;
  assign sum_ext   = {1'b0, sum_q} + {1'b0, MOD_TAB[in_i.key_char]};
  assign sum_mod   = (sum_ext >= SIZE_EXT) ? SLOT_W'(sum_ext - SIZE_EXT) : SLOT_W'(sum_ext);

  // Name compare against the slot read back: only bytes below the length count.
  always_comb begin
    for (int i = 0; i < MAX_NAME_BYTES; i++) begin
      lane_ok[i] = (LEN_W'(i) >= len_q) || (rd_q.name[i] == name_q[i]);
    end
  end

  assign slot_hit  = rd_q.used && (rd_q.len == len_q) && (&lane_ok);
  assign probe_end = (probe_q == SLOT_LAST);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP: begin
        if (sweep_q == SLOT_LAST) begin
          state_d = clr_res_q ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.op == OP_CLEAR) begin
            state_d = S_SWEEP;
          end else if ((in_i.op inside {OP_INSERT, OP_LOOKUP}) && in_i.key_last) begin
            state_d = name_long ? S_EMIT : S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_q.used || slot_hit || probe_end) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and sequencer outputs.
  always_comb begin
    sweep_d      = sweep_q;
    clr_res_d    = clr_res_q;
    loc_d        = loc_q;
    probe_d      = probe_q;
    name_d       = name_q;
    len_d        = len_q;
    sum_d        = sum_q;
    too_long_d   = too_long_q;
    is_insert_d  = is_insert_q;
    offs_d       = offs_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_offs_d   = res_offs_q;
    we           = 1'b0;
    waddr        = loc_q;
    wdata        = '0;
    wdata.used   = 1'b1;
    wdata.len    = len_q;
    wdata.name   = name_q;
    wdata.offs   = offs_q;

    case (state_q)
      S_SWEEP: begin
        // Mark one slot empty per cycle.
        we         = 1'b1;
        waddr      = sweep_q;
        wdata.used = 1'b0;
        sweep_d    = sweep_q + 1'b1;
        if (sweep_q == SLOT_LAST) begin
          sweep_d      = '0;
          res_status_d = ST_CLEARED;
          res_slot_d   = '0;
          res_offs_d   = '0;
        end
      end
      S_IDLE: begin
        if (in_acc && in_i.op == OP_CLEAR) begin
          clr_res_d  = 1'b1;
          sweep_d    = '0;
          count_d    = '0;
          len_d      = '0;
          sum_d      = '0;
          too_long_d = 1'b0;
        end else if (in_acc && (in_i.op inside {OP_INSERT, OP_LOOKUP})) begin
          // Take in one name byte, or note that the name overflowed.
          if (byte_fits) begin
            name_d[len_q[IDX_W-1:0]] = in_i.key_char;
            len_d = len_q + 1'b1;
            sum_d = sum_mod;
          end else begin
            too_long_d = 1'b1;
          end
          if (in_i.key_last) begin
            is_insert_d = (in_i.op == OP_INSERT);
            offs_d      = in_i.data_offset;
            probe_d     = '0;
            loc_d       = byte_fits ? sum_mod : sum_q;
            if (name_long) begin
              res_status_d = ST_TOO_LONG;
              res_slot_d   = '0;
              res_offs_d   = '0;
              len_d        = '0;
              sum_d        = '0;
              too_long_d   = 1'b0;
            end
          end
        end
      end
      S_CHECK: begin
        if (!rd_q.used || slot_hit || probe_end) begin
          // Probe finished: drop the received name.
          len_d      = '0;
          sum_d      = '0;
          too_long_d = 1'b0;
          res_slot_d = '0;
          res_offs_d = '0;
          if (slot_hit) begin
            res_slot_d   = SLOT_OUT_W'(loc_q);
            res_status_d = is_insert_q ? ST_DUPLICATE : ST_FOUND;
            if (!is_insert_q) begin
              res_offs_d = rd_q.offs;
            end
          end else if (!rd_q.used) begin
            if (is_insert_q) begin
              we           = 1'b1;
              res_status_d = ST_INSERTED;
              res_slot_d   = SLOT_OUT_W'(loc_q);
              if (count_q != COUNT_MAX) begin
                count_d = count_q + 1'b1;
              end
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end else begin
            res_status_d = is_insert_q ? ST_FULL : ST_NOT_FOUND;
          end
        end else begin
          // Step to the next slot, wrapping at the end of the table.
          probe_d = probe_q + 1'b1;
          loc_d   = (loc_q == SLOT_LAST) ? '0 : loc_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          clr_res_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register between the sequencer and the output channel.
  always_comb begin
    out_d              = out_q;
    out_valid_d        = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_d.status       = res_status_q;
      out_d.slot         = res_slot_q;
      out_d.found_offset = res_offs_q;
      out_d.over_limit   = (count_q > limit_q);
      out_valid_d        = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      clr_res_q   <= 1'b0;
      len_q       <= '0;
      sum_q       <= '0;
      too_long_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      loc_q       <= '0;
      probe_q     <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_res_q   <= clr_res_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      too_long_q  <= too_long_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      loc_q       <= loc_d;
      probe_q     <= probe_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    name_q       <= name_d;
    is_insert_q  <= is_insert_d;
    offs_q       <= offs_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_offs_q   <= res_offs_d;
    out_q        <= out_d;
  end

  // Slot memory: one write port, one registered read port at the probe slot.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[loc_q];
  end

endmodule
